### rtl/core/djs_pkg.sv
// Shared constants for the deadline job scheduler.
package djs_pkg;
  localparam int MAX_JOBS     = 32;
  localparam int MAX_DEADLINE = 32;
  localparam int IDX_W        = $clog2(MAX_JOBS);
  localparam int SLOT_W       = $clog2(MAX_DEADLINE);
  localparam int CNT_W        = 6;
  localparam int ID_W         = 8;
  localparam int DL_W         = 6;
  localparam int PF_W         = 16;
  localparam int TOT_W        = 21;
endpackage

### rtl/core/djs_pick_cmp.sv
// Shared compare unit that decides whether a candidate job beats the current best.
module djs_pick_cmp (
  input  logic [djs_pkg::PF_W-1:0] cand_pf,
  input  logic [djs_pkg::PF_W-1:0] best_pf,
  input  logic                     cand_taken,
  input  logic                     best_found,
  output logic                     take
);
  // Strictly greater keeps the earliest arrival on equal profit.
  assign take = !cand_taken && (!best_found || (cand_pf > best_pf));
endmodule

### rtl/core/deadline_job_scheduler.sv
// Top level of the deadline job scheduler.
// Jobs are loaded one word per cycle while in_stall is low; the word with
// in_last_job set closes the set and the block then stalls its input. Scheduling
// repeatedly scans the n stored jobs with one shared compare unit to pick the
// highest unplaced profit, then walks slots downward from the deadline one per
// cycle. Results then come out in slot order, one slot examined per cycle, each
// result held until out_stall is low.
module deadline_job_scheduler (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       in_valid,
  output logic                       in_stall,
  input  logic [djs_pkg::ID_W-1:0]   in_job_id,
  input  logic [djs_pkg::DL_W-1:0]   in_deadline,
  input  logic [djs_pkg::PF_W-1:0]   in_profit,
  input  logic                       in_last_job,
  output logic                       out_valid,
  input  logic                       out_stall,
  output logic                       out_has_job,
  output logic [djs_pkg::ID_W-1:0]   out_job_id,
  output logic [djs_pkg::DL_W-1:0]   out_slot_number,
  output logic [djs_pkg::CNT_W-1:0]  out_jobs_done,
  output logic [djs_pkg::TOT_W-1:0]  out_total_profit,
  output logic                       out_overflow,
  output logic                       out_last_result
);
  localparam logic [2:0] ST_LOAD   = 3'd0;
  localparam logic [2:0] ST_PICK   = 3'd1;
  localparam logic [2:0] ST_DECIDE = 3'd2;
  localparam logic [2:0] ST_PLACE  = 3'd3;
  localparam logic [2:0] ST_EMIT   = 3'd4;

  logic [2:0] state_r;
  logic [djs_pkg::ID_W-1:0]  id_r [djs_pkg::MAX_JOBS];
  logic [djs_pkg::DL_W-1:0]  dl_r [djs_pkg::MAX_JOBS];
  logic [djs_pkg::PF_W-1:0]  pf_r [djs_pkg::MAX_JOBS];
  logic [djs_pkg::MAX_JOBS-1:0] taken_r;
  logic [djs_pkg::MAX_DEADLINE:0] used_r;
  logic [djs_pkg::ID_W-1:0]  owner_r [djs_pkg::MAX_DEADLINE];
  logic [djs_pkg::CNT_W-1:0] job_cnt_r, done_cnt_r;
  logic [djs_pkg::DL_W-1:0]  slot_r, last_slot_r;
  logic [djs_pkg::IDX_W-1:0] scan_r, best_r;
  logic [djs_pkg::PF_W-1:0]  best_pf_r;
  logic                      found_r, dropped_r;
  logic [djs_pkg::TOT_W-1:0] total_r;
  logic                      take, in_acc, fin, emit_hit;
  logic [djs_pkg::DL_W-1:0]  dl_sat;
  logic [djs_pkg::SLOT_W-1:0] slot_idx;

  djs_pick_cmp u_cmp (
    .cand_pf   (pf_r[scan_r]),
    .best_pf   (best_pf_r),
    .cand_taken(taken_r[scan_r]),
    .best_found(found_r),
    .take      (take)
  );

  assign in_stall = (state_r != ST_LOAD);
  assign in_acc   = in_valid && !in_stall;
  assign dl_sat   = (in_deadline > djs_pkg::DL_W'(djs_pkg::MAX_DEADLINE)) ?
                    djs_pkg::DL_W'(djs_pkg::MAX_DEADLINE) : in_deadline;
  // Slots run from 1, so the owner table is kept one entry lower.
  assign slot_idx = djs_pkg::SLOT_W'(slot_r - 1'b1);

  assign emit_hit = (done_cnt_r == '0) || used_r[slot_r];
  assign fin      = (done_cnt_r == '0) || (slot_r == last_slot_r);
  assign out_valid        = (state_r == ST_EMIT) && emit_hit;
  assign out_has_job      = (done_cnt_r != '0);
  assign out_job_id       = out_has_job ? owner_r[slot_idx] : '0;
  assign out_slot_number  = out_has_job ? slot_r : '0;
  assign out_jobs_done    = fin ? done_cnt_r : '0;
  assign out_total_profit = fin ? total_r : '0;
  assign out_overflow     = fin && dropped_r;
  assign out_last_result  = fin;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_LOAD;
      job_cnt_r   <= '0;
      dropped_r   <= 1'b0;
      used_r      <= '0;
      taken_r     <= '0;
      done_cnt_r  <= '0;
      total_r     <= '0;
      last_slot_r <= '0;
      found_r     <= 1'b0;
      scan_r      <= '0;
      slot_r      <= '0;
    end else begin
      unique case (state_r)
        ST_LOAD: begin
          if (in_acc) begin
            if (job_cnt_r < djs_pkg::CNT_W'(djs_pkg::MAX_JOBS)) begin
              id_r[job_cnt_r[djs_pkg::IDX_W-1:0]] <= in_job_id;
              dl_r[job_cnt_r[djs_pkg::IDX_W-1:0]] <= dl_sat;
              pf_r[job_cnt_r[djs_pkg::IDX_W-1:0]] <= in_profit;
              job_cnt_r <= job_cnt_r + 1'b1;
            end else begin
              dropped_r <= 1'b1;
            end
            if (in_last_job) begin
              state_r <= ST_PICK;
              scan_r  <= '0;
              found_r <= 1'b0;
              taken_r <= '0;
            end
          end
        end
        ST_PICK: begin
          if (take) begin
            best_r    <= scan_r;
            best_pf_r <= pf_r[scan_r];
            found_r   <= 1'b1;
          end
          if ({1'b0, scan_r} == job_cnt_r - 1'b1) state_r <= ST_DECIDE;
          else scan_r <= scan_r + 1'b1;
        end
        ST_DECIDE: begin
          if (!found_r) begin
            state_r <= ST_EMIT;
            slot_r  <= djs_pkg::DL_W'(1);
          end else begin
            taken_r[best_r] <= 1'b1;
            slot_r  <= dl_r[best_r];
            state_r <= ST_PLACE;
          end
        end
        ST_PLACE: begin
          if (slot_r == '0) begin
            state_r <= ST_PICK;
            scan_r  <= '0;
            found_r <= 1'b0;
          end else if (!used_r[slot_r]) begin
            used_r[slot_r]    <= 1'b1;
            owner_r[slot_idx] <= id_r[best_r];
            total_r    <= total_r + djs_pkg::TOT_W'(best_pf_r);
            done_cnt_r <= done_cnt_r + 1'b1;
            if (slot_r > last_slot_r) last_slot_r <= slot_r;
            state_r <= ST_PICK;
            scan_r  <= '0;
            found_r <= 1'b0;
          end else begin
            slot_r <= slot_r - 1'b1;
          end
        end
        ST_EMIT: begin
          if (!emit_hit) begin
            slot_r <= slot_r + 1'b1;
          end else if (!out_stall) begin
            if (fin) begin
              state_r     <= ST_LOAD;
              job_cnt_r   <= '0;
              dropped_r   <= 1'b0;
              used_r      <= '0;
              done_cnt_r  <= '0;
              total_r     <= '0;
              last_slot_r <= '0;
            end else begin
              slot_r <= slot_r + 1'b1;
            end
          end
        end
        default: state_r <= ST_LOAD;
      endcase
    end
  end

  a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
    job_cnt_r <= djs_pkg::CNT_W'(djs_pkg::MAX_JOBS))
    else $error("job count beyond capacity");
  a_slot_zero: assert property (@(posedge clk) disable iff (!rst_n) !used_r[0])
    else $error("slot zero marked used");
  a_done_fit: assert property (@(posedge clk) disable iff (!rst_n)
    done_cnt_r <= job_cnt_r)
    else $error("more jobs placed than loaded");
  a_fin_clear: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_stall && out_last_result) |=> (state_r == ST_LOAD && used_r == '0))
    else $error("set not cleared after final word");
endmodule

### test/deadline_job_scheduler_tb.sv
// Self-checking testbench for the deadline job scheduler.
module deadline_job_scheduler_tb;
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct packed {
    logic [djs_pkg::ID_W-1:0] job_id;
    logic [djs_pkg::DL_W-1:0] deadline;
    logic [djs_pkg::PF_W-1:0] profit;
    logic                     last_job;
  } job_word_t;

  typedef struct packed {
    logic                      has_job;
    logic [djs_pkg::ID_W-1:0]  job_id;
    logic [djs_pkg::DL_W-1:0]  slot_number;
    logic [djs_pkg::CNT_W-1:0] jobs_done;
    logic [djs_pkg::TOT_W-1:0] total_profit;
    logic                      overflow;
    logic                      last_result;
  } slot_word_t;

  localparam int WATCHDOG_CYCLES = 200000;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_stall;
  logic [djs_pkg::ID_W-1:0] in_job_id = '0;
  logic [djs_pkg::DL_W-1:0] in_deadline = '0;
  logic [djs_pkg::PF_W-1:0] in_profit = '0;
  logic in_last_job = 1'b0;
  logic out_valid;
  logic out_stall = 1'b1;
  logic out_has_job;
  logic [djs_pkg::ID_W-1:0] out_job_id;
  logic [djs_pkg::DL_W-1:0] out_slot_number;
  logic [djs_pkg::CNT_W-1:0] out_jobs_done;
  logic [djs_pkg::TOT_W-1:0] out_total_profit;
  logic out_overflow;
  logic out_last_result;

  deadline_job_scheduler dut (.*);

  always #10 clk = ~clk;

  job_word_t  pending_jobs[$];
  slot_word_t expected_slots[$];
  int error_count = 0;
  int idle_count = 0;
  bit quiet_mode = 1'b0;
  bit hold_sender = 1'b0;
  bit in_accepted = 1'b0;
  int in_gap = 0;
  int out_gap = 0;

  // Predictor state for the set being loaded.
  logic [djs_pkg::ID_W-1:0] held_ids[djs_pkg::MAX_JOBS];
  int              held_deadlines[djs_pkg::MAX_JOBS];
  int              held_profits[djs_pkg::MAX_JOBS];
  int              held_count = 0;
  bit              held_dropped = 1'b0;

  task automatic report_mismatch(input string what, input longint got, input longint want);
    $display("mismatch %s: got %0d expected %0d at %0t", what, got, want, $realtime);
    error_count++;
  endtask

  // Store one accepted job and, when it closes the set, compute the schedule.
  task automatic schedule_job(input job_word_t w);
    int rank[djs_pkg::MAX_JOBS];
    int owner[djs_pkg::MAX_DEADLINE+1];
    bit used[djs_pkg::MAX_DEADLINE+1];
    int n, done, total, final_slot, k, s;
    slot_word_t r;
    if (held_count < djs_pkg::MAX_JOBS) begin
      held_ids[held_count] = w.job_id;
      held_deadlines[held_count] = (int'(w.deadline) > djs_pkg::MAX_DEADLINE) ?
                                   djs_pkg::MAX_DEADLINE : int'(w.deadline);
      held_profits[held_count] = int'(w.profit);
      held_count++;
    end else begin
      held_dropped = 1'b1;
    end
    if (!w.last_job) return;
    n = held_count;
    for (int i = 0; i < n; i++) begin
      k = i;
      while (k > 0 && held_profits[rank[k-1]] < held_profits[i]) begin
        rank[k] = rank[k-1];
        k--;
      end
      rank[k] = i;
    end
    for (int i = 0; i <= djs_pkg::MAX_DEADLINE; i++) used[i] = 1'b0;
    done = 0; total = 0; final_slot = 0;
    for (int i = 0; i < n; i++) begin
      for (s = held_deadlines[rank[i]]; s > 0; s--) begin
        if (!used[s]) begin
          used[s] = 1'b1;
          owner[s] = rank[i];
          total += held_profits[rank[i]];
          done++;
          if (s > final_slot) final_slot = s;
          break;
        end
      end
    end
    if (done == 0) begin
      r = '0;
      r.overflow = held_dropped;
      r.last_result = 1'b1;
      expected_slots.push_back(r);
    end else begin
      for (s = 1; s <= djs_pkg::MAX_DEADLINE; s++) begin
        if (used[s]) begin
          r = '0;
          r.has_job = 1'b1;
          r.job_id = held_ids[owner[s]];
          r.slot_number = djs_pkg::DL_W'(s);
          if (s == final_slot) begin
            r.jobs_done = djs_pkg::CNT_W'(done);
            r.total_profit = djs_pkg::TOT_W'(total);
            r.overflow = held_dropped;
            r.last_result = 1'b1;
          end
          expected_slots.push_back(r);
        end
      end
    end
    held_count = 0;
    held_dropped = 1'b0;
  endtask

  always @(negedge clk) begin
    if (rst_n) begin
      if (in_valid && !in_accepted) begin
        // Word stays put until it is taken.
      end else begin
        in_accepted = 1'b0;
        if (in_gap > 0) begin
          in_gap--;
          in_valid <= 1'b0;
        end else if (pending_jobs.size() != 0 && !hold_sender) begin
          if (!quiet_mode && $urandom_range(0, 5) == 0) begin
            in_gap = $urandom_range(0, 4);
            in_valid <= 1'b0;
          end else begin
            in_valid <= 1'b1;
            in_job_id <= pending_jobs[0].job_id;
            in_deadline <= pending_jobs[0].deadline;
            in_profit <= pending_jobs[0].profit;
            in_last_job <= pending_jobs[0].last_job;
            pending_jobs.pop_front();
          end
        end else begin
          in_valid <= 1'b0;
        end
      end
      if (out_gap > 0) begin
        out_gap--;
        out_stall <= 1'b1;
      end else if (!quiet_mode && $urandom_range(0, 5) == 0) begin
        out_gap = $urandom_range(0, 4);
        out_stall <= 1'b1;
      end else begin
        out_stall <= 1'b0;
      end
    end
  end

  always @(posedge clk) begin
    if (rst_n) begin
      bit moved;
      moved = 1'b0;
      if (in_valid && !in_stall) begin
        moved = 1'b1;
        in_accepted = 1'b1;
        schedule_job('{in_job_id, in_deadline, in_profit, in_last_job});
      end
      if (out_valid && !out_stall) begin
        slot_word_t want;
        moved = 1'b1;
        if (expected_slots.size() == 0) begin
          report_mismatch("unexpected word", 1, 0);
        end else begin
          want = expected_slots.pop_front();
          if (out_has_job !== want.has_job)
            report_mismatch("has_job", out_has_job, want.has_job);
          if (out_job_id !== want.job_id) report_mismatch("job_id", out_job_id, want.job_id);
          if (out_slot_number !== want.slot_number)
            report_mismatch("slot_number", out_slot_number, want.slot_number);
          if (out_jobs_done !== want.jobs_done)
            report_mismatch("jobs_done", out_jobs_done, want.jobs_done);
          if (out_total_profit !== want.total_profit)
            report_mismatch("total_profit", out_total_profit, want.total_profit);
          if (out_overflow !== want.overflow)
            report_mismatch("overflow", out_overflow, want.overflow);
          if (out_last_result !== want.last_result)
            report_mismatch("last_result", out_last_result, want.last_result);
        end
      end
      idle_count <= moved ? 0 : idle_count + 1;
      if (idle_count >= WATCHDOG_CYCLES) begin
        $display("== FAIL ==");
        $finish;
      end
    end
  end

  function automatic job_word_t make_job(int id, int dl, int pf, bit last);
    job_word_t w;
    w.job_id = djs_pkg::ID_W'(id);
    w.deadline = djs_pkg::DL_W'(dl);
    w.profit = djs_pkg::PF_W'(pf);
    w.last_job = last;
    return w;
  endfunction

  // Random set: mostly small, deadlines often short so jobs compete for slots.
  task automatic queue_random_set(input int n);
    int dl;
    for (int i = 0; i < n; i++) begin
      case ($urandom_range(0, 9))
        0: dl = 0;
        1: dl = $urandom_range(33, 63);
        2: dl = $urandom_range(1, 32);
        default: dl = $urandom_range(1, (n < 8) ? 8 : n);
      endcase
      pending_jobs.push_back(make_job($urandom_range(0, 255), dl,
        ($urandom_range(0, 3) == 0) ? $urandom_range(0, 7) : $urandom_range(0, 65535),
        i == n - 1));
    end
  endtask

  initial begin
    int sent;
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    // Directed: classic example, ties, zero and large deadlines.
    pending_jobs.push_back(make_job(8'hA1, 2, 100, 0));
    pending_jobs.push_back(make_job(8'hB2, 1, 19, 0));
    pending_jobs.push_back(make_job(8'hC3, 2, 27, 0));
    pending_jobs.push_back(make_job(8'hD4, 1, 25, 0));
    pending_jobs.push_back(make_job(8'hE5, 3, 15, 1));
    pending_jobs.push_back(make_job(8'h00, 0, 65535, 1));
    pending_jobs.push_back(make_job(8'hFF, 63, 65535, 0));
    pending_jobs.push_back(make_job(8'h55, 1, 7, 0));
    pending_jobs.push_back(make_job(8'hAA, 1, 7, 0));
    pending_jobs.push_back(make_job(8'h3C, 33, 0, 0));
    pending_jobs.push_back(make_job(8'h01, 0, 0, 1));
    // Overflow: 34 jobs with a dropped closing word.
    for (int i = 0; i < 34; i++)
      pending_jobs.push_back(make_job(i, 32 - (i % 32), 65535 - i, i == 33));
    // Wait out every expected word before the next phase.
    wait (pending_jobs.size() == 0);
    hold_sender = 1'b1;
    wait (expected_slots.size() == 0 && !in_valid);
    hold_sender = 1'b0;
    sent = 45;
    while (sent < 220) begin
      int n;
      n = ($urandom_range(0, 9) == 0) ? $urandom_range(20, 36) : $urandom_range(1, 8);
      if (n > 220 - sent) n = 220 - sent;
      queue_random_set(n);
      sent += n;
      if (sent > 180) quiet_mode = 1'b1;
      wait (pending_jobs.size() < 40);
    end
    wait (pending_jobs.size() == 0 && !in_valid);
    wait (expected_slots.size() == 0);
    repeat (50) @(posedge clk);
    if (error_count == 0 && expected_slots.size() == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end
endmodule
